>>> rtl/rvsu_pkg.sv
package rvsu_pkg;

  // Pixel depth register codes
  localparam logic [3:0] DEPTH_1BPP  = 4'd0;
  localparam logic [3:0] DEPTH_2BPP  = 4'd1;
  localparam logic [3:0] DEPTH_4BPP  = 4'd2;
  localparam logic [3:0] DEPTH_8BPP  = 4'd3;
  localparam logic [3:0] DEPTH_16BPP = 4'd4;
  localparam logic [3:0] DEPTH_24BPP = 4'd5;
  localparam logic [3:0] DEPTH_32BPP = 4'd6;
  localparam logic [3:0] DEPTH_GRAY2 = 4'd7;
  localparam logic [3:0] DEPTH_GRAY4 = 4'd8;
  localparam logic [3:0] DEPTH_GRAY8 = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_DEPTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [12:0] MAX_HEIGHT        = 13'd4096;
  localparam logic [2:0]  INDEXED_PIX_BYTES = 3'd3;
  localparam int unsigned CMD_FIFO_DEPTH    = 4;

  typedef enum logic [1:0] {
    CMD_PAL_WRITE,
    CMD_INDEXED,
    CMD_DIRECT
  } cmd_kind_e;

  // Work handed from the front end to the pixel engine.
  // CMD_PAL_WRITE: data = {color, index}
  // CMD_INDEXED:   data[7:0] = packed byte, npix pixels of 2**bpp_log bits
  // CMD_DIRECT:    data = {b3, b2, b1, b0}, one pixel
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] data;
    logic [1:0]  bpp_log;
    logic [3:0]  npix;
    logic [2:0]  byte_count;
    logic        eol;
    logic        eof;
  } cmd_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  byte_count;
    logic        last;
    logic        eol;
    logic        eof;
  } pix_t;

  typedef struct packed {
    logic       direct;
    logic [1:0] bpp_log;
    logic [2:0] nbytes;
  } mode_t;

  function automatic mode_t decode_depth(logic [3:0] code);
    mode_t m;
    m = '{direct: 1'b0, bpp_log: 2'd3, nbytes: 3'd1};
    unique case (code)
      DEPTH_1BPP:               m.bpp_log = 2'd0;
      DEPTH_2BPP, DEPTH_GRAY2:  m.bpp_log = 2'd1;
      DEPTH_4BPP, DEPTH_GRAY4:  m.bpp_log = 2'd2;
      DEPTH_8BPP, DEPTH_GRAY8:  m.bpp_log = 2'd3;
      DEPTH_16BPP: begin
        m.direct = 1'b1;
        m.nbytes = 3'd2;
      end
      DEPTH_24BPP: begin
        m.direct = 1'b1;
        m.nbytes = 3'd3;
      end
      DEPTH_32BPP: begin
        m.direct = 1'b1;
        m.nbytes = 3'd4;
      end
      default:                  m.bpp_log = 2'd3;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/rvsu_ram.sv
module rvsu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rvsu_front.sv
module rvsu_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic           s_op_i,
  input  logic [7:0]     s_byte_i,
  input  logic [7:0]     s_pidx_i,
  input  logic [23:0]    s_pcolor_i,
  input  logic           cfg_valid_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [12:0]    cfg_data_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output rvsu_pkg::cmd_t cmd_o
);
  import rvsu_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned BW = $clog2(4 * MAX_WIDTH + 1);

  logic [3:0]    depth_q;
  logic [12:0]   width_q;
  logic [12:0]   height_q;
  logic [BW-1:0] bil_q;
  logic [WW-1:0] pix_q;
  logic [11:0]   line_q;
  logic [23:0]   partial_q;
  logic [1:0]    bip_q;

  mode_t         mode;
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [BW-1:0] wx;
  logic [BW-1:0] bpl_raw;
  logic [BW-1:0] bpl;
  logic          accept;
  logic          pix_active;
  logic [WW-1:0] rem;
  logic [3:0]    per;
  logic [3:0]    npix;
  logic [3:0]    n_emit;
  logic [WW:0]   pix_sum;
  logic          eol;
  logic          last_line;
  logic          direct_last;
  logic          line_end;
  logic          push;
  cmd_t          cmd;

  assign mode = decode_depth(depth_q);

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = 13'd1;
    end else if (height_q > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = height_q;
    end
  end

  // Bytes per line, rounded up to an even count
  assign wx = BW'(w_eff);
  always_comb begin
    if (!mode.direct) begin
      unique case (mode.bpp_log)
        2'd0: bpl_raw = (wx + BW'(7)) >> 3;
        2'd1: bpl_raw = (wx + BW'(3)) >> 2;
        2'd2: bpl_raw = (wx + BW'(1)) >> 1;
        2'd3: bpl_raw = wx;
        default: bpl_raw = wx;
      endcase
    end else begin
      unique case (mode.nbytes)
        3'd2:    bpl_raw = wx << 1;
        3'd3:    bpl_raw = wx + (wx << 1);
        default: bpl_raw = wx << 2;
      endcase
    end
    bpl = bpl_raw + BW'(bpl_raw[0]);
  end

  assign s_ready_o = cmd_ready_i;
  assign accept    = s_valid_i && s_ready_o;

  assign pix_active  = pix_q < w_eff;
  assign rem         = w_eff - pix_q;
  assign per         = 4'd8 >> mode.bpp_log;
  assign npix        = (rem < WW'(per)) ? 4'(rem) : per;
  assign n_emit      = mode.direct ? 4'd1 : npix;
  assign pix_sum     = (WW + 1)'(pix_q) + (WW + 1)'(n_emit);
  assign eol         = pix_sum >= (WW + 1)'(w_eff);
  assign last_line   = (13'(line_q) + 13'd1) >= h_eff;
  assign direct_last = (3'(bip_q) + 3'd1) >= mode.nbytes;
  assign line_end    = ((BW + 1)'(bil_q) + (BW + 1)'(1)) >= (BW + 1)'(bpl);

  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_INDEXED;
    push     = 1'b0;
    if (s_op_i) begin
      cmd.kind = CMD_PAL_WRITE;
      cmd.data = {s_pcolor_i, s_pidx_i};
      push     = 1'b1;
    end else if (pix_active) begin
      cmd.npix = n_emit;
      cmd.eol  = eol;
      cmd.eof  = eol && last_line;
      if (!mode.direct) begin
        cmd.kind       = CMD_INDEXED;
        cmd.data       = {24'd0, s_byte_i};
        cmd.bpp_log    = mode.bpp_log;
        cmd.byte_count = INDEXED_PIX_BYTES;
        push           = 1'b1;
      end else if (direct_last) begin
        cmd.kind       = CMD_DIRECT;
        cmd.byte_count = mode.nbytes;
        push           = 1'b1;
        unique case (mode.nbytes)
          3'd2:    cmd.data = {16'd0, partial_q[7:0], s_byte_i};
          3'd3:    cmd.data = {8'd0, s_byte_i, partial_q[7:0], partial_q[15:8]};
          default: cmd.data = {partial_q[23:16], s_byte_i, partial_q[7:0],
                               partial_q[15:8]};
        endcase
      end
    end
  end

  assign cmd_valid_o = accept && push;
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= DEPTH_8BPP;
      width_q   <= 13'd640;
      height_q  <= 13'd480;
      bil_q     <= '0;
      pix_q     <= '0;
      line_q    <= '0;
      partial_q <= '0;
      bip_q     <= '0;
    end else begin
      priority if (cfg_valid_i && (cfg_index_i == REG_PIXEL_DEPTH ||
                   cfg_index_i == REG_IMAGE_WIDTH ||
                   cfg_index_i == REG_IMAGE_HEIGHT)) begin
        unique case (cfg_index_i)
          REG_PIXEL_DEPTH: depth_q  <= cfg_data_i[3:0];
          REG_IMAGE_WIDTH: width_q  <= cfg_data_i;
          default:         height_q <= cfg_data_i;
        endcase
        bil_q     <= '0;
        pix_q     <= '0;
        line_q    <= '0;
        partial_q <= '0;
        bip_q     <= '0;
      end else if (accept && !s_op_i) begin
        // Line done: rewind the position and step the line counter
        if (line_end) begin
          bil_q     <= '0;
          pix_q     <= '0;
          partial_q <= '0;
          bip_q     <= '0;
          line_q    <= last_line ? 12'd0 : line_q + 12'd1;
        end else begin
          bil_q <= bil_q + BW'(1);
          if (pix_active) begin
            if (!mode.direct || direct_last) begin
              pix_q     <= WW'(pix_sum);
              partial_q <= '0;
              bip_q     <= '0;
            end else begin
              partial_q <= {partial_q[15:0], s_byte_i};
              bip_q     <= bip_q + 2'd1;
            end
          end
        end
      end else begin
        bil_q <= bil_q;
      end
    end
  end

endmodule

>>> rtl/rvsu_fifo.sv
module rvsu_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rvsu_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rvsu_pkg::cmd_t pop_data_o
);
  import rvsu_pkg::*;

  localparam int unsigned PW = $clog2(CMD_FIFO_DEPTH);

  cmd_t          entry_q [CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [PW:0]   count_q;
  logic          do_push;
  logic          do_pop;

  assign push_ready_o = count_q != (PW + 1)'(CMD_FIFO_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (PW + 1)'(1);
        2'b01:   count_q <= count_q - (PW + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/rvsu_back.sv
module rvsu_back #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  rvsu_pkg::cmd_t cmd_i,
  output logic           pix_valid_o,
  input  logic           pix_ready_i,
  output rvsu_pkg::pix_t pix_o
);
  import rvsu_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  logic [2:0]    k_q;
  logic          s1_v_q;
  logic          s1_indexed_q;
  logic          s1_oob_q;
  logic [31:0]   s1_bytes_q;
  logic [2:0]    s1_count_q;
  logic          s1_last_q;
  logic          s1_eol_q;
  logic          s1_eof_q;
  logic          out_v_q;
  pix_t          out_q;

  logic          adv_out;
  logic          s1_ready;
  logic          issue;
  logic          last_pix;
  logic          pop;
  logic          pal_we;
  logic [2:0]    sh;
  logic [7:0]    shifted;
  logic [7:0]    idx;
  logic          oob;
  logic [23:0]   rdata;
  logic [31:0]   s1_out_bytes;

  assign adv_out  = !out_v_q || pix_ready_i;
  assign s1_ready = !s1_v_q || adv_out;
  assign last_pix = (4'(k_q) + 4'd1) >= cmd_i.npix;

  always_comb begin
    issue  = 1'b0;
    pop    = 1'b0;
    pal_we = 1'b0;
    unique case (cmd_i.kind)
      CMD_PAL_WRITE: begin
        pop    = cmd_valid_i;
        pal_we = cmd_valid_i && (32'(cmd_i.data[7:0]) < PALETTE_ENTRIES);
      end
      CMD_INDEXED: begin
        issue = cmd_valid_i && s1_ready;
        pop   = issue && last_pix;
      end
      CMD_DIRECT: begin
        issue = cmd_valid_i && s1_ready;
        pop   = issue;
      end
      default: begin
        pop = cmd_valid_i;
      end
    endcase
  end

  assign cmd_ready_o = pop;

  // Pick pixel k of the byte, most significant bits first
  assign sh      = k_q << cmd_i.bpp_log;
  assign shifted = cmd_i.data[7:0] << sh;
  always_comb begin
    unique case (cmd_i.bpp_log)
      2'd0:    idx = {7'd0, shifted[7]};
      2'd1:    idx = {6'd0, shifted[7:6]};
      2'd2:    idx = {4'd0, shifted[7:4]};
      default: idx = shifted;
    endcase
  end
  assign oob = 32'(idx) >= PALETTE_ENTRIES;

  rvsu_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (cmd_i.data[AW-1:0]),
    .wdata_i (cmd_i.data[31:8]),
    .re_i    (issue && cmd_i.kind == CMD_INDEXED),
    .raddr_i (idx[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    if (!s1_indexed_q) begin
      s1_out_bytes = s1_bytes_q;
    end else if (s1_oob_q) begin
      s1_out_bytes = '0;
    end else begin
      s1_out_bytes = {8'd0, rdata[7:0], rdata[15:8], rdata[23:16]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_indexed_q <= cmd_i.kind == CMD_INDEXED;
      s1_oob_q     <= oob;
      s1_bytes_q   <= cmd_i.data;
      s1_count_q   <= cmd_i.byte_count;
      s1_last_q    <= pop;
      s1_eol_q     <= pop && cmd_i.eol;
      s1_eof_q     <= pop && cmd_i.eof;
    end
    if (adv_out && s1_v_q) begin
      out_q.bytes      <= s1_out_bytes;
      out_q.byte_count <= s1_count_q;
      out_q.last       <= s1_last_q;
      out_q.eol        <= s1_eol_q;
      out_q.eof        <= s1_eof_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (issue && cmd_i.kind == CMD_INDEXED) begin
        k_q <= pop ? 3'd0 : k_q + 3'd1;
      end
      if (issue) begin
        s1_v_q <= 1'b1;
      end else if (adv_out) begin
        s1_v_q <= 1'b0;
      end
      if (adv_out) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  assign pix_valid_o = out_v_q;
  assign pix_o       = out_q;

endmodule

>>> rtl/raw_video_scanline_unpacker.sv
// Path: a frame byte accepted at the input reaches the output through the queue entry,
// the palette read stage and the output register.
// Throughput: one input byte per cycle in 8, 16, 24 and 32 bpp while the queue has room;
// in 1, 2 and 4 bpp the pixel engine emits one pixel per cycle unless the output stalls,
// set by the single palette read port, so a byte holding n pixels occupies it until all n are issued.
// Reset: registers return to 8 bpp, 640 x 480, position zero; palette undefined.
module raw_video_scanline_unpacker #(
  parameter int unsigned MAX_WIDTH       = 4096,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // data_byte [7:0], palette_index [15:8], palette_color [39:16]
  input  logic [39:0] s_axis_tdata_i,
  // operation [0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_byte0 [7:0], out_byte1 [15:8], out_byte2 [23:16], out_byte3 [31:24],
  // byte_count [34:32], zero [39:35]
  output logic [39:0] m_axis_tdata_o,
  // last_of_run
  output logic        m_axis_tlast_o,
  // end_of_line [0], end_of_frame [1]
  output logic [1:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import rvsu_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;
  pix_t pix;

  assign cfg_ready_o = 1'b1;

  rvsu_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_op_i      (s_axis_tuser_i),
    .s_byte_i    (s_axis_tdata_i[7:0]),
    .s_pidx_i    (s_axis_tdata_i[15:8]),
    .s_pcolor_i  (s_axis_tdata_i[39:16]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rvsu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  rvsu_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .pix_valid_o (m_axis_tvalid_o),
    .pix_ready_i (m_axis_tready_i),
    .pix_o       (pix)
  );

  assign m_axis_tdata_o = {5'd0, pix.byte_count, pix.bytes};
  assign m_axis_tlast_o = pix.last;
  assign m_axis_tuser_o = {pix.eof, pix.eol};

endmodule
